[rtl/csr_to_block_csr_converter_unit_macros.svh]
// Assertion macros for the CSR to block CSR converter.
// Included by the converter unit, which carries the concurrent checks; no other dependencies.
`ifndef CSR_TO_BLOCK_CSR_CONVERTER_UNIT_MACROS_SVH
`define CSR_TO_BLOCK_CSR_CONVERTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted
`define C2B_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define C2B_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define C2B_ASSERT(lbl, clk, rst_n, prop, msg)
`define C2B_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[rtl/c2b_pkg.sv]
// Shared widths, codes, control structs and helpers of the CSR to block CSR converter.
// No dependencies; the other RTL modules and interfaces import it.
package c2b_pkg;

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int COL_W   = 12;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 24;
    localparam int BS_W    = 7;
    localparam int EPOCH_W = 16;
    localparam int RIB_W   = 6;

    // Default capacities
    localparam int C_MAX_COLS   = 4096;
    localparam int C_MAX_ROWS   = 4096;
    localparam int C_MAX_VALUES = 16777216;

    // Saturation and range limits
    localparam logic [IDX_W-1:0] CNT_MAX  = {IDX_W{1'b1}};
    localparam logic [BS_W-1:0]  EDGE_MAX = BS_W'(64);

    // Input word function codes
    localparam logic [FUNC_W-1:0] FUNC_NZ      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ROW_END = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_START   = 2'd2;

    // Output word kinds
    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_ROWPTR = 1'b1;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Tag memory access control
    typedef struct packed {
        logic en;
        logic we;
    } t_mem_ctl;

    // Effective block edge: zero acts as one, large values clamp to 64
    function automatic logic [BS_W-1:0] edge_of(input logic [BS_W-1:0] bs);
        logic [BS_W-1:0] e;
        if (bs == '0) begin
            e = BS_W'(1);
        end else if (bs > EDGE_MAX) begin
            e = EDGE_MAX;
        end else begin
            e = bs;
        end
        return e;
    endfunction

endpackage

[rtl/c2b_ifs.sv]
// Valid/ready channel interfaces for input and result words.
// Depends on c2b_pkg for field widths.
interface c2b_in_if;
    import c2b_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [COL_W-1:0]  col;
    logic [VAL_W-1:0]  value;

    modport source (output valid, func, col, value, input ready);
    modport sink   (input valid, func, col, value, output ready);
endinterface

interface c2b_out_if;
    import c2b_pkg::*;
    logic             valid;
    logic             ready;
    logic             kind;
    logic             new_block;
    logic [COL_W-1:0] block_col;
    logic [IDX_W-1:0] dest_index;
    logic [VAL_W-1:0] out_value;
    logic [IDX_W-1:0] row_pointer;
    logic             overflow;

    modport source (output valid, kind, new_block, block_col, dest_index, out_value,
                    row_pointer, overflow, input ready);
    modport sink   (input valid, kind, new_block, block_col, dest_index, out_value,
                    row_pointer, overflow, output ready);
endinterface

[rtl/c2b_div.sv]
// Restoring divider, one quotient bit per cycle: column by block edge.
// Depends on c2b_pkg for widths and the status struct.
module c2b_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [c2b_pkg::COL_W-1:0]   i_dividend,
    input  logic [c2b_pkg::BS_W-1:0]    i_divisor,
    output logic [c2b_pkg::COL_W-1:0]   o_quot,
    output logic [c2b_pkg::BS_W-1:0]    o_rem,
    output c2b_pkg::t_div_stat          o_stat
);
    import c2b_pkg::*;

    localparam int CNT_W = $clog2(COL_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [COL_W-1:0] r_quo;
    logic [BS_W-1:0]  r_rem;
    logic [BS_W-1:0]  r_dvs;

    logic [BS_W:0] trial;
    logic [BS_W:0] diff;
    logic          ge;

    // Shift in next dividend bit and try a subtract
    assign trial = {r_rem, r_quo[COL_W-1]};
    assign ge    = (trial >= {1'b0, r_dvs});
    assign diff  = trial - {1'b0, r_dvs};

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(COL_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath, no reset
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[COL_W-2:0], ge};
            r_rem <= ge ? diff[BS_W-1:0] : trial[BS_W-1:0];
        end
    end

    assign o_quot      = r_quo;
    assign o_rem       = r_rem;
    assign o_stat.busy = r_busy;
    // Last step in progress; results are registered at this edge
    assign o_stat.done = r_busy && (r_cnt == CNT_W'(COL_W - 1));

endmodule

[rtl/c2b_tag_mem.sv]
// Single-port tag memory, one access per cycle, registered read data.
// Depends on c2b_pkg for the access control struct.
module c2b_tag_mem #(
    parameter int DEPTH = c2b_pkg::C_MAX_COLS,
    parameter int WIDTH = 52
) (
    input  logic                     i_clk,
    input  c2b_pkg::t_mem_ctl        i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    import c2b_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write or read, one per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/csr_to_block_csr_converter_unit.sv]
// CSR to block CSR converter: a nonzero word passes, after its acceptance, through a decode
// state, the 12-step column divider, a tag memory read, compare/allocate write-back, slot
// multiply and destination add, and back to the idle state that takes the next word. Row-end
// and start-of-matrix words pass only through the decode state. A result waits in its last
// state while the output register is full. One word is in flight at a time; a finished result
// sits in an output register so the next word is taken while it waits.
// After reset, and after every start word that wraps the 16-bit matrix epoch, all MAX_COLS
// entries of the tag memory (4096 by default) are swept clear with input held off;
// block_size writes are taken during the sweep. Depends on c2b_pkg, c2b_ifs,
// c2b_div, c2b_tag_mem and the assertion macro header.
`include "csr_to_block_csr_converter_unit_macros.svh"

module csr_to_block_csr_converter_unit #(
    parameter int MAX_COLS   = c2b_pkg::C_MAX_COLS,
    parameter int MAX_ROWS   = c2b_pkg::C_MAX_ROWS,
    parameter int MAX_VALUES = c2b_pkg::C_MAX_VALUES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    c2b_in_if.sink                    i_in,
    c2b_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [c2b_pkg::BS_W-1:0]  i_cfg_wdata
);
    import c2b_pkg::*;

    localparam int TI_W   = $clog2(MAX_COLS);
    localparam int BR_W   = $clog2(MAX_ROWS);
    localparam int TAG_W  = EPOCH_W + BR_W + IDX_W;
    localparam int EE_W   = 2 * BS_W;
    localparam int OFF_W  = RIB_W + BS_W + 1;
    localparam int PROD_W = IDX_W + EE_W;
    localparam int DEST_W = PROD_W + 1;
    // Reduction steps for block column modulo MAX_COLS
    localparam int RED_STEPS = (MAX_COLS >= (1 << COL_W)) ? 0 :
                               $clog2(((1 << COL_W) + MAX_COLS - 1) / MAX_COLS);
    localparam longint DEST_CAP = (longint'(MAX_VALUES) < (longint'(1) << IDX_W)) ?
                                  longint'(MAX_VALUES) : (longint'(1) << IDX_W);
    localparam logic [DEST_W-1:0] DEST_CAP_V = DEST_W'(DEST_CAP);
    localparam logic [IDX_W-1:0]  DEST_SAT   = IDX_W'(DEST_CAP - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_LOOK,
        S_CMP,
        S_MUL,
        S_FIN
    } t_state;

    // Control state
    t_state              r_state;
    logic [BS_W-1:0]     r_block_size;
    logic [TI_W-1:0]     r_clr_addr;
    logic [RIB_W-1:0]    r_rib;
    logic [BR_W-1:0]     r_brow;
    logic [IDX_W-1:0]    r_block_count;
    logic [EPOCH_W-1:0]  r_epoch;
    logic                r_cap_flag;
    logic                r_out_valid;

    // Per-word payload
    logic [FUNC_W-1:0]   r_func;
    logic [COL_W-1:0]    r_col;
    logic [VAL_W-1:0]    r_value;
    logic [COL_W-1:0]    r_bcol;
    logic [TI_W-1:0]     r_ti;
    logic [OFF_W-1:0]    r_rowoff;
    logic [EE_W-1:0]     r_ee;
    logic [IDX_W-1:0]    r_slot;
    logic                r_fresh;
    logic                r_ovf;
    logic [PROD_W-1:0]   r_prod;

    // Output register
    logic                r_o_kind;
    logic                r_o_new_block;
    logic [COL_W-1:0]    r_o_block_col;
    logic [IDX_W-1:0]    r_o_dest_index;
    logic [VAL_W-1:0]    r_o_out_value;
    logic [IDX_W-1:0]    r_o_row_pointer;
    logic                r_o_overflow;

    logic [BS_W-1:0]     blk_edge;
    logic                in_fire;
    logic                out_free;
    logic                row_close;
    logic [EPOCH_W-1:0]  epoch_inc;

    logic                div_start;
    logic [COL_W-1:0]    div_quot;
    logic [BS_W-1:0]     div_rem;
    t_div_stat           div_stat;

    t_mem_ctl            mem_ctl;
    logic [TI_W-1:0]     mem_addr;
    logic [TAG_W-1:0]    mem_wdata;
    logic [TAG_W-1:0]    mem_rdata;

    logic [31:0]         red_val;
    logic [TI_W-1:0]     look_ti;
    logic [EPOCH_W-1:0]  tag_epoch;
    logic [BR_W-1:0]     tag_brow;
    logic [IDX_W-1:0]    tag_slot;
    logic                tag_hit;
    logic                cnt_full;
    logic [DEST_W-1:0]   dest_sum;
    logic                dest_ovf;
    logic [IDX_W-1:0]    dest_final;
    logic                fin_load;
    logic                rowptr_load;

    assign blk_edge  = edge_of(r_block_size);
    assign in_fire   = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign row_close = ({1'b0, r_rib} + (RIB_W + 1)'(1)) >= (RIB_W + 1)'(blk_edge);
    assign epoch_inc = r_epoch + EPOCH_W'(1);
    assign div_start = (r_state == S_EXEC) && (r_func == FUNC_NZ);

    c2b_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_col),
        .i_divisor  (blk_edge),
        .o_quot     (div_quot),
        .o_rem      (div_rem),
        .o_stat     (div_stat)
    );

    // Block column reduced into the tag memory range
    always_comb begin
        red_val = 32'(div_quot);
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            if (red_val >= (32'(MAX_COLS) << k)) begin
                red_val = red_val - (32'(MAX_COLS) << k);
            end
        end
        look_ti = red_val[TI_W-1:0];
    end

    // Tag memory port mux: sweep, lookup read, allocate write
    always_comb begin
        mem_ctl   = '0;
        mem_addr  = r_ti;
        mem_wdata = {r_epoch, r_brow, r_block_count};
        case (r_state)
            S_CLEAR: begin
                mem_ctl.en = 1'b1;
                mem_ctl.we = 1'b1;
                mem_addr   = r_clr_addr;
                mem_wdata  = '0;
            end
            S_LOOK: begin
                mem_ctl.en = 1'b1;
                mem_addr   = look_ti;
            end
            S_CMP: begin
                mem_ctl.en = !tag_hit && !cnt_full;
                mem_ctl.we = 1'b1;
            end
            default: begin
                mem_ctl = '0;
            end
        endcase
    end

    c2b_tag_mem #(
        .DEPTH (MAX_COLS),
        .WIDTH (TAG_W)
    ) u_tag_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Tag compare
    assign {tag_epoch, tag_brow, tag_slot} = mem_rdata;
    assign tag_hit  = (tag_epoch == r_epoch) && (tag_brow == r_brow);
    assign cnt_full = (r_block_count >= CNT_MAX);

    // Destination add and saturation
    assign dest_sum    = {1'b0, r_prod} + DEST_W'(r_rowoff);
    assign dest_ovf    = (dest_sum >= DEST_CAP_V);
    assign dest_final  = dest_ovf ? DEST_SAT : dest_sum[IDX_W-1:0];
    assign fin_load    = (r_state == S_FIN) && out_free;
    assign rowptr_load = (r_state == S_EXEC) && (r_func == FUNC_ROW_END) && row_close &&
                         out_free;

    // Sequencer, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_block_size  <= BS_W'(1);
            r_clr_addr    <= '0;
            r_rib         <= '0;
            r_brow        <= '0;
            r_block_count <= '0;
            r_epoch       <= EPOCH_W'(1);
            r_cap_flag    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_block_size <= i_cfg_wdata;
            end
            // Output valid: set on a load, cleared once taken
            if (fin_load || rowptr_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= (r_clr_addr == TI_W'(MAX_COLS - 1)) ?
                                  '0 : r_clr_addr + TI_W'(1);
                    if (r_clr_addr == TI_W'(MAX_COLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_func  <= i_in.func;
                        r_col   <= i_in.col;
                        r_value <= i_in.value;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_func)
                        FUNC_NZ: begin
                            r_state <= S_DIV;
                        end
                        FUNC_ROW_END: begin
                            if (!row_close) begin
                                r_rib   <= r_rib + RIB_W'(1);
                                r_state <= S_IDLE;
                            end else if (out_free) begin
                                // Block row closes: report the row pointer
                                r_rib           <= '0;
                                r_brow          <= (r_brow == BR_W'(MAX_ROWS - 1)) ?
                                                   '0 : r_brow + BR_W'(1);
                                r_o_kind        <= KIND_ROWPTR;
                                r_o_new_block   <= 1'b0;
                                r_o_block_col   <= '0;
                                r_o_dest_index  <= '0;
                                r_o_out_value   <= '0;
                                r_o_row_pointer <= r_block_count;
                                r_o_overflow    <= r_cap_flag;
                                r_state         <= S_IDLE;
                            end
                        end
                        FUNC_START: begin
                            r_rib         <= '0;
                            r_brow        <= '0;
                            r_block_count <= '0;
                            r_cap_flag    <= 1'b0;
                            if (epoch_inc == '0) begin
                                // Epoch wrapped: sweep the tags
                                r_epoch    <= EPOCH_W'(1);
                                r_clr_addr <= '0;
                                r_state    <= S_CLEAR;
                            end else begin
                                r_epoch <= epoch_inc;
                                r_state <= S_IDLE;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_bcol   <= div_quot;
                    r_ti     <= look_ti;
                    r_rowoff <= OFF_W'(r_rib) * OFF_W'(blk_edge) + OFF_W'(div_rem);
                    r_ee     <= EE_W'(blk_edge) * EE_W'(blk_edge);
                    r_state  <= S_CMP;
                end
                S_CMP: begin
                    if (tag_hit) begin
                        r_slot  <= tag_slot;
                        r_fresh <= 1'b0;
                        r_ovf   <= 1'b0;
                    end else if (cnt_full) begin
                        r_slot  <= CNT_MAX;
                        r_fresh <= 1'b0;
                        r_ovf   <= 1'b1;
                    end else begin
                        r_slot        <= r_block_count;
                        r_fresh       <= 1'b1;
                        r_ovf         <= 1'b0;
                        r_block_count <= r_block_count + IDX_W'(1);
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_slot) * PROD_W'(r_ee);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_o_kind        <= KIND_VALUE;
                        r_o_new_block   <= r_fresh;
                        r_o_block_col   <= r_bcol;
                        r_o_dest_index  <= dest_final;
                        r_o_out_value   <= r_value;
                        r_o_row_pointer <= '0;
                        r_o_overflow    <= r_ovf || dest_ovf;
                        if (r_ovf || dest_ovf) begin
                            r_cap_flag <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_o_kind;
    assign o_out.new_block   = r_o_new_block;
    assign o_out.block_col   = r_o_block_col;
    assign o_out.dest_index  = r_o_dest_index;
    assign o_out.out_value   = r_o_out_value;
    assign o_out.row_pointer = r_o_row_pointer;
    assign o_out.overflow    = r_o_overflow;

    // Checks
    `C2B_ASSERT(a_alloc_counts, i_clk, i_rst_n, (r_state == S_CMP && !tag_hit && !cnt_full) |=> (r_block_count == $past(r_block_count) + IDX_W'(1)), "allocation did not advance block count")
    `C2B_ASSERT(a_ovf_sticky, i_clk, i_rst_n, (fin_load && (r_ovf || dest_ovf)) |=> r_cap_flag, "overflow not recorded in sticky flag")
    `C2B_ASSERT(a_epoch_nonzero, i_clk, i_rst_n, (r_state != S_CLEAR) |-> (r_epoch != '0), "matrix epoch is zero outside the sweep")
    `C2B_ASSERT(a_div_owned, i_clk, i_rst_n, div_stat.done |-> (r_state == S_DIV), "divider finished outside its wait state")
    `C2B_ASSERT(a_no_load_full, i_clk, i_rst_n, (r_out_valid && !o_out.ready) |=> ($stable(r_o_dest_index) && $stable(r_o_kind)), "output word changed while stalled")

endmodule
